// ===== sv/dss_pkg.sv =====
// Shared types, constants, command table and helpers for the deployment step sequencer.
package dss_pkg;

	localparam int NUM_STEPS_DEF = 24;
	localparam int TIME_W        = 40;
	localparam int BURN_W        = 24;
	localparam int IDX_W         = 5;
	localparam int TABLE_LEN     = 24;
	localparam int RUN_LIMIT     = 12;
	localparam int RUN_W         = 4;
	localparam int UPC_W         = 4;
	localparam int APB_AW        = 4;
	localparam int APB_DW        = 64;

	localparam logic [TIME_W-1:0] TIME_MAX      = '1;
	localparam logic [TIME_W-1:0] AUTO_OPEN_RST = 40'd3456000000;
	localparam logic [BURN_W-1:0] BURN_WAIT_RST = 24'd120000;

	// item kinds
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_OPEN = 2'd1;
	localparam logic [1:0] FUNC_CORR = 2'd2;

	// persisted modes
	localparam logic [1:0] MODE_WAITING = 2'd0;
	localparam logic [1:0] MODE_OPENING = 2'd1;
	localparam logic [1:0] MODE_STOPPED = 2'd2;

	// register index (paddr[3])
	localparam logic REG_AUTO_OPEN = 1'b0;
	localparam logic REG_BURN_WAIT = 1'b1;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_IGNORE_OVERHEAT,
		CMD_MAIN_KNIFE_ON,
		CMD_MAIN_KNIFE_OFF,
		CMD_RED_KNIFE_ON,
		CMD_RED_KNIFE_OFF,
		CMD_MAIN_BURN,
		CMD_RED_BURN,
		CMD_DELAY_100MS,
		CMD_WAIT
	} cmd_t;

	localparam cmd_t STEP_TABLE [TABLE_LEN] = '{
		CMD_IGNORE_OVERHEAT, CMD_MAIN_KNIFE_ON, CMD_DELAY_100MS, CMD_MAIN_KNIFE_ON,
		CMD_DELAY_100MS, CMD_MAIN_BURN, CMD_DELAY_100MS, CMD_MAIN_BURN, CMD_WAIT,
		CMD_MAIN_KNIFE_OFF, CMD_DELAY_100MS, CMD_MAIN_KNIFE_OFF, CMD_DELAY_100MS,
		CMD_RED_KNIFE_ON, CMD_DELAY_100MS, CMD_RED_KNIFE_ON, CMD_DELAY_100MS,
		CMD_RED_BURN, CMD_DELAY_100MS, CMD_RED_BURN, CMD_WAIT,
		CMD_RED_KNIFE_OFF, CMD_DELAY_100MS, CMD_RED_KNIFE_OFF
	};

	typedef enum logic [2:0] {
		OP_NOP,
		OP_MODE,
		OP_STEP,
		OP_STATUS,
		OP_SETREQ,
		OP_CORR,
		OP_BAD,
		OP_END
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_FUNC_OPEN,
		C_FUNC_CORR,
		C_NOT_TICK,
		C_NOT_OK,
		C_NO_RUN,
		C_NOT_PROG,
		C_MORE
	} cond_t;

	// microprogram addresses
	localparam logic [UPC_W-1:0] UA_START  = 4'd0;
	localparam logic [UPC_W-1:0] UA_RUN    = 4'd7;
	localparam logic [UPC_W-1:0] UA_END    = 4'd8;
	localparam logic [UPC_W-1:0] UA_STATUS = 4'd9;
	localparam logic [UPC_W-1:0] UA_SETREQ = 4'd10;
	localparam logic [UPC_W-1:0] UA_CORR   = 4'd11;
	localparam logic [UPC_W-1:0] UA_BAD    = 4'd12;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic func_open;
		logic func_corr;
		logic not_tick;
		logic not_ok;
		logic no_run;
		logic not_prog;
		logic more;
	} flags_t;

	typedef struct packed {
		logic start;
		logic go;
		op_t  op;
	} dp_ctl_t;

	typedef struct packed {
		logic [1:0]               func;
		logic [TIME_W-1:0]        time_ms;
		logic [1:0]               stored_mode;
		logic                     stored_mode_ok;
		logic signed [TIME_W-1:0] correction_ms;
	} req_t;

	typedef struct packed {
		logic [3:0]       command;
		logic [IDX_W-1:0] step_index;
		logic             mode_write;
		logic             update_ok;
		logic             last;
	} rsp_t;

	function automatic cmd_t step_cmd(input logic [IDX_W-1:0] idx);
		cmd_t c;
		c = CMD_NONE;
		if (idx < IDX_W'(TABLE_LEN))
			c = STEP_TABLE[idx];
		return c;
	endfunction

	function automatic logic op_emits(input op_t op);
		return (op == OP_STEP) || (op == OP_STATUS) || (op == OP_BAD);
	endfunction

endpackage

// ===== sv/dss_sequencer.sv =====
// Microcode sequencer: program ROM, micro program counter, conditional jumps.
module dss_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dss_pkg::flags_t flags,
	input  logic            out_load,
	output logic            busy,
	output dss_pkg::dp_ctl_t dp_ctl
);
	import dss_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic             busy_q;
	ctrl_t            ctrl;
	logic             jump;
	logic             go;

	// program
	always_comb begin
		unique case (upc_q)
			4'd0:    ctrl = '{OP_NOP,    C_FUNC_OPEN, UA_SETREQ};
			4'd1:    ctrl = '{OP_NOP,    C_FUNC_CORR, UA_CORR};
			4'd2:    ctrl = '{OP_NOP,    C_NOT_TICK,  UA_END};
			4'd3:    ctrl = '{OP_NOP,    C_NOT_OK,    UA_BAD};
			4'd4:    ctrl = '{OP_MODE,   C_NEVER,     UA_START};
			4'd5:    ctrl = '{OP_NOP,    C_NO_RUN,    UA_STATUS};
			4'd6:    ctrl = '{OP_NOP,    C_NOT_PROG,  UA_STATUS};
			4'd7:    ctrl = '{OP_STEP,   C_MORE,      UA_RUN};
			4'd8:    ctrl = '{OP_END,    C_NEVER,     UA_END};
			4'd9:    ctrl = '{OP_STATUS, C_ALWAYS,    UA_END};
			4'd10:   ctrl = '{OP_SETREQ, C_ALWAYS,    UA_END};
			4'd11:   ctrl = '{OP_CORR,   C_ALWAYS,    UA_END};
			4'd12:   ctrl = '{OP_BAD,    C_ALWAYS,    UA_END};
			default: ctrl = '{OP_END,    C_NEVER,     UA_END};
		endcase
	end

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_FUNC_OPEN: jump = flags.func_open;
			C_FUNC_CORR: jump = flags.func_corr;
			C_NOT_TICK:  jump = flags.not_tick;
			C_NOT_OK:    jump = flags.not_ok;
			C_NO_RUN:    jump = flags.no_run;
			C_NOT_PROG:  jump = flags.not_prog;
			C_MORE:      jump = flags.more;
			default:     jump = 1'b0;
		endcase
	end

	// an emitting word waits for room in the output register
	assign go = !op_emits(ctrl.op) || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= UA_END;
			busy_q <= 1'b0;
		end else if (start) begin
			upc_q  <= UA_START;
			busy_q <= 1'b1;
		end else if (busy_q && go) begin
			if (ctrl.op == OP_END)
				busy_q <= 1'b0;
			else
				upc_q <= jump ? ctrl.target : upc_q + 1'b1;
		end
	end

	assign busy      = busy_q;
	assign dp_ctl.start = start;
	assign dp_ctl.go    = busy_q && go;
	assign dp_ctl.op    = ctrl.op;

endmodule

// ===== sv/dss_datapath.sv =====
// Datapath: item register, step counter, next step time, open request and result forming.
module dss_datapath #(
	parameter int NUM_STEPS = dss_pkg::NUM_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dss_pkg::dp_ctl_t               dp_ctl,
	input  dss_pkg::req_t                  req,
	input  logic [dss_pkg::TIME_W-1:0]     auto_open_ms,
	input  logic [dss_pkg::BURN_W-1:0]     burn_wait_ms,
	output dss_pkg::flags_t                flags,
	output dss_pkg::rsp_t                  rsp
);
	import dss_pkg::*;

	localparam int              CNT_W = $clog2(NUM_STEPS + 1);
	localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_STEPS);

	req_t              req_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] nst_q;
	logic              pend_q;
	logic              mw_q;
	logic              opening_q;
	logic [RUN_W-1:0]  run_q;

	logic [TIME_W-1:0] now;
	logic [IDX_W-1:0]  idx;
	logic [CNT_W-1:0]  cnt_inc;
	cmd_t              cmd;
	logic [TIME_W:0]   burn_sum;
	logic [TIME_W-1:0] nst_step;
	logic              step_end;
	logic              mw_n;
	logic              open_n;
	logic [TIME_W+1:0] corr_sum;
	logic [TIME_W-1:0] corr_res;

	assign now     = req_q.time_ms;
	assign idx     = IDX_W'(cnt_q);
	assign cnt_inc = cnt_q + 1'b1;
	assign cmd     = step_cmd(idx);

	// wait step: saturating now + burn wait
	assign burn_sum = {1'b0, now} + (TIME_W + 1)'(burn_wait_ms);
	assign nst_step = (cmd == CMD_WAIT) ? (burn_sum[TIME_W] ? TIME_MAX : burn_sum[TIME_W-1:0])
	                                    : now;
	assign step_end = (nst_step > now) || (cnt_inc >= NUM_C) ||
	                  (run_q == RUN_W'(RUN_LIMIT - 1));

	// mode update
	always_comb begin
		mw_n   = 1'b0;
		open_n = 1'b0;
		unique case (req_q.stored_mode)
			MODE_OPENING: begin
				mw_n   = pend_q && (cnt_q >= NUM_C);
				open_n = 1'b1;
			end
			MODE_STOPPED: mw_n = pend_q;
			MODE_WAITING: mw_n = (now >= auto_open_ms) || pend_q;
			default:      mw_n = 1'b0;
		endcase
		if (mw_n)
			open_n = 1'b1;
	end

	// saturating signed correction
	assign corr_sum = {2'b00, nst_q} + {{2{req_q.correction_ms[TIME_W-1]}}, req_q.correction_ms};
	assign corr_res = corr_sum[TIME_W+1] ? '0 :
	                  corr_sum[TIME_W]   ? TIME_MAX : corr_sum[TIME_W-1:0];

	assign flags.func_open = (req_q.func == FUNC_OPEN);
	assign flags.func_corr = (req_q.func == FUNC_CORR);
	assign flags.not_tick  = (req_q.func != FUNC_TICK);
	assign flags.not_ok    = !req_q.stored_mode_ok;
	assign flags.no_run    = !(opening_q && (now >= nst_q));
	assign flags.not_prog  = (cnt_q >= NUM_C);
	assign flags.more      = !step_end;

	always_comb begin
		rsp = '0;
		unique case (dp_ctl.op)
			OP_STEP:   rsp = '{cmd, idx, mw_q, 1'b1, step_end};
			OP_STATUS: rsp = '{CMD_NONE, '0, mw_q, 1'b1, 1'b1};
			OP_BAD:    rsp = '{CMD_NONE, '0, 1'b0, 1'b0, 1'b1};
			default:   rsp = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dp_ctl.start)
			req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			nst_q     <= '0;
			pend_q    <= 1'b0;
			mw_q      <= 1'b0;
			opening_q <= 1'b0;
			run_q     <= '0;
		end else if (dp_ctl.start) begin
			run_q <= '0;
		end else if (dp_ctl.go) begin
			unique case (dp_ctl.op)
				OP_MODE: begin
					pend_q    <= 1'b0;
					mw_q      <= mw_n;
					opening_q <= open_n;
					if (mw_n) begin
						cnt_q <= '0;
						nst_q <= '0;
					end
				end
				OP_STEP: begin
					cnt_q <= cnt_inc;
					nst_q <= nst_step;
					run_q <= run_q + 1'b1;
				end
				OP_SETREQ: pend_q <= 1'b1;
				OP_CORR:   nst_q  <= corr_res;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/deployment_step_sequencer_unit.sv =====
// Top level of the deployment step sequencer: APB registers, sequencer, datapath, result register.
//
// Usage:
//  req channel (req_valid/req_ready, payload req): one item per handshake; func selects
//    mission tick, open request or time correction.
//  rsp channel (rsp_valid/rsp_ready, payload rsp): results of a tick, one per executed
//    table step (at most twelve), or one status result; rsp.last marks the final one.
//    Open requests and corrections give no result.
//  APB port: auto_open_after_ms at 0x0, burn_wait_ms at 0x8, 64-bit data, no wait states.
//    Write only while the block is idle.
// Timing: one control word per cycle while no result word waits. Each item runs dispatch
//  words, then by kind the set-request word, the correction word, the bad-mode word for an
//  unreadable mode, or the mode and run-check words and then the step word once per executed
//  step or the status word, and ends in the end word. The next item is taken the cycle after
//  the end word. The first step result is registered by the first step word, and an
//  unreadable-mode result by the bad-mode word. req_ready is high while the sequencer is
//  idle; the next item is taken while the last result still waits in the output register.
// Stall: a result word waits when the output register is full and rsp_ready is low;
//  the step counter and next step time hold until it moves.
// Reset: step counter, next step time and open request clear; registers take their
//  reset values; the output register empties.
module deployment_step_sequencer_unit #(
	parameter int NUM_STEPS = dss_pkg::NUM_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  dss_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output dss_pkg::rsp_t              rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dss_pkg::APB_AW-1:0] paddr,
	input  logic [dss_pkg::APB_DW-1:0] pwdata,
	output logic [dss_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import dss_pkg::*;

	logic [TIME_W-1:0] auto_open_q;
	logic [BURN_W-1:0] burn_wait_q;
	logic              reg_wr;
	logic              busy;
	logic              start;
	logic              out_load;
	flags_t            flags;
	dp_ctl_t           dp_ctl;
	rsp_t              rsp_n;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// APB: registers sit 8 bytes apart, paddr[3] picks one
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_open_q <= AUTO_OPEN_RST;
			burn_wait_q <= BURN_WAIT_RST;
		end else if (reg_wr) begin
			unique case (paddr[3])
				REG_AUTO_OPEN: auto_open_q <= pwdata[TIME_W-1:0];
				REG_BURN_WAIT: burn_wait_q <= pwdata[BURN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_AUTO_OPEN: prdata = APB_DW'(auto_open_q);
			REG_BURN_WAIT: prdata = APB_DW'(burn_wait_q);
			default:       prdata = '0;
		endcase
	end

	assign req_ready = !busy;
	assign start     = req_valid && !busy;
	assign out_load  = !rsp_valid_q || rsp_ready;

	dss_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.flags    (flags),
		.out_load (out_load),
		.busy     (busy),
		.dp_ctl   (dp_ctl)
	);

	dss_datapath #(
		.NUM_STEPS (NUM_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_ctl       (dp_ctl),
		.req          (req),
		.auto_open_ms (auto_open_q),
		.burn_wait_ms (burn_wait_q),
		.flags        (flags),
		.rsp          (rsp_n)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (dp_ctl.go && op_emits(dp_ctl.op))
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dp_ctl.go && op_emits(dp_ctl.op))
			rsp_q <= rsp_n;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("sequencer idle right after taking an item");

	a_bad_mode_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.update_ok |-> rsp.last && !rsp.mode_write)
		else $error("unreadable mode result must be single and write nothing");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while sequencer idle");
`endif

endmodule

// ===== bench/deploy_seq_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the deployment step sequencer: predicts every result item and checks it.
module deploy_seq_checker #(
	parameter int NUM_STEPS = dss_pkg::NUM_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  dss_pkg::req_t              req,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  dss_pkg::rsp_t              rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [dss_pkg::APB_AW-1:0] paddr,
	input  logic [dss_pkg::APB_DW-1:0] pwdata,
	output int                         mismatches,
	output int                         pending,
	output int                         items_taken,
	output int                         results_checked
);
	import dss_pkg::*;

	localparam int SEQ_LEN = 24;
	localparam int MAX_RUN = 12;

	// deployment table, one command per step
	localparam cmd_t DEPLOY_SEQ [SEQ_LEN] = '{
		CMD_IGNORE_OVERHEAT, CMD_MAIN_KNIFE_ON, CMD_DELAY_100MS, CMD_MAIN_KNIFE_ON,
		CMD_DELAY_100MS, CMD_MAIN_BURN, CMD_DELAY_100MS, CMD_MAIN_BURN, CMD_WAIT,
		CMD_MAIN_KNIFE_OFF, CMD_DELAY_100MS, CMD_MAIN_KNIFE_OFF, CMD_DELAY_100MS,
		CMD_RED_KNIFE_ON, CMD_DELAY_100MS, CMD_RED_KNIFE_ON, CMD_DELAY_100MS,
		CMD_RED_BURN, CMD_DELAY_100MS, CMD_RED_BURN, CMD_WAIT,
		CMD_RED_KNIFE_OFF, CMD_DELAY_100MS, CMD_RED_KNIFE_OFF
	};

	logic [TIME_W-1:0] auto_open_ms = AUTO_OPEN_RST;
	logic [BURN_W-1:0] burn_ms      = BURN_WAIT_RST;
	logic [TIME_W-1:0] next_at      = '0;
	logic [IDX_W-1:0]  step_cnt     = '0;
	logic              open_pend    = 1'b0;
	rsp_t              expected_results [$];
	int                mismatch_cnt = 0;
	int                pending_cnt  = 0;
	int                item_cnt     = 0;
	int                result_cnt   = 0;

	assign mismatches      = mismatch_cnt;
	assign pending         = pending_cnt;
	assign items_taken     = item_cnt;
	assign results_checked = result_cnt;

	function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W:0] s);
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	// advance the sequencer by one item, queueing the results it causes
	task automatic advance_sequencer(input req_t it);
		logic             asked;
		logic             opening;
		logic             write_mode;
		logic [TIME_W:0]  mag;
		logic [IDX_W-1:0] idx;
		cmd_t             cmd;
		rsp_t             r;
		int               n;
		n = 0;
		opening = 1'b0;
		write_mode = 1'b0;
		case (it.func)
		FUNC_OPEN: open_pend = 1'b1;
		FUNC_CORR: begin
			if (it.correction_ms < 0) begin
				mag = {1'b1, {TIME_W{1'b0}}} - {1'b0, it.correction_ms};
				next_at = ({1'b0, next_at} >= mag) ? next_at - mag[TIME_W-1:0] : '0;
			end else begin
				next_at = sat_sum({1'b0, next_at} + {1'b0, it.correction_ms});
			end
		end
		FUNC_TICK: begin
			if (!it.stored_mode_ok) begin
				// unreadable mode: bare status, state untouched
				r = '0;
				r.last = 1'b1;
				expected_results.push_back(r);
			end else begin
				asked = open_pend;
				open_pend = 1'b0;
				case (it.stored_mode)
				MODE_OPENING: begin
					if (asked && int'(step_cnt) >= NUM_STEPS)
						write_mode = 1'b1;
					opening = 1'b1;
				end
				MODE_STOPPED: write_mode = asked;
				MODE_WAITING: write_mode = asked || (it.time_ms >= auto_open_ms);
				default: ;
				endcase
				if (write_mode) begin
					opening = 1'b1;
					step_cnt = '0;
					next_at = '0;
				end
				if (opening && it.time_ms >= next_at) begin
					while (int'(step_cnt) < NUM_STEPS && n < MAX_RUN) begin
						idx = step_cnt;
						cmd = (int'(idx) < SEQ_LEN) ? DEPLOY_SEQ[idx] : CMD_NONE;
						step_cnt = step_cnt + 1'b1;
						if (cmd == CMD_WAIT)
							next_at = sat_sum({1'b0, it.time_ms} + (TIME_W+1)'(burn_ms));
						else
							next_at = it.time_ms;
						r = '0;
						r.command = cmd;
						r.step_index = idx;
						r.mode_write = write_mode;
						r.update_ok = 1'b1;
						expected_results.push_back(r);
						n++;
						if (next_at > it.time_ms)
							break;
					end
				end
				if (n == 0) begin
					r = '0;
					r.mode_write = write_mode;
					r.update_ok = 1'b1;
					expected_results.push_back(r);
				end
				expected_results[expected_results.size()-1].last = 1'b1;
			end
		end
		default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			auto_open_ms = AUTO_OPEN_RST;
			burn_ms = BURN_WAIT_RST;
			next_at = '0;
			step_cnt = '0;
			open_pend = 1'b0;
			expected_results.delete();
			pending_cnt = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_BURN_WAIT)
					burn_ms = pwdata[BURN_W-1:0];
				else
					auto_open_ms = pwdata[TIME_W-1:0];
			end
			if (rsp_valid && rsp_ready) begin
				result_cnt++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: command %0d step %0d",
						rsp.command, rsp.step_index);
					mismatch_cnt++;
				end else begin
					want = expected_results.pop_front();
					check_field("command", want.command, rsp.command);
					check_field("step_index", want.step_index, rsp.step_index);
					check_field("mode_write", want.mode_write, rsp.mode_write);
					check_field("update_ok", want.update_ok, rsp.update_ok);
					check_field("last", want.last, rsp.last);
				end
			end
			if (req_valid && req_ready) begin
				item_cnt++;
				advance_sequencer(req);
			end
			pending_cnt = expected_results.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the sequencer testbench: clock, reset, stimulus, output stalls and the verdict.
module testbench;
	import dss_pkg::*;

	// item kind and mode codes the package leaves unnamed
	localparam logic [1:0] FUNC_RSVD    = 2'd3;
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;

	localparam logic [APB_AW-1:0] ADDR_AUTO_OPEN = {REG_AUTO_OPEN, 3'b000};
	localparam logic [APB_AW-1:0] ADDR_BURN_WAIT = {REG_BURN_WAIT, 3'b000};

	localparam logic [TIME_W-1:0] CORR_MOST_NEG = 40'h80_0000_0000;
	localparam logic [TIME_W-1:0] CORR_MOST_POS = 40'h7F_FFFF_FFFF;

	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;  // long output hold-off
	localparam int PRESSURE_LEN  = 20;
	localparam int ITEMS_PER_SET = 60;
	localparam int LIMIT_NS      = 5_000_000;

	typedef enum {FLOW_FREE, FLOW_RANDOM, FLOW_CHOKED} flow_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_t                req;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_t                rsp;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int                  mismatches;
	int                  pending;
	int                  items_taken;
	int                  results_checked;

	logic                hold_request;  // stimulus asks the receiver for one long hold
	int                  burst_left;
	logic [TIME_W-1:0]   mission;       // running mission clock for well-formed ticks
	logic [BURN_W-1:0]   cur_burn;      // burn wait as last written, to pace the clock

	deployment_step_sequencer_unit i_dut (.*);

	deploy_seq_checker i_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#LIMIT_NS;
		$display("deployment_step_sequencer_unit verification failed");
		$finish;
	end

	function automatic logic [TIME_W-1:0] rand40();
		logic [TIME_W-1:0] v;
		v[31:0] = $urandom();
		v[TIME_W-1:32] = 8'($urandom_range(0, 255));
		return v;
	endfunction

	function automatic req_t make_item(input logic [1:0] f, input logic [TIME_W-1:0] t,
			input logic [1:0] m, input logic ok, input logic [TIME_W-1:0] c);
		req_t it;
		it.func = f;
		it.time_ms = t;
		it.stored_mode = m;
		it.stored_mode_ok = ok;
		it.correction_ms = c;
		return it;
	endfunction

	// Mostly mission-like items: the clock creeps, jumps past a burn wait or
	// leaps; about one item in ten is pure noise over every field.
	task automatic next_random_item(output req_t it);
		int                r;
		logic [TIME_W:0]   adv;
		logic [TIME_W-1:0] mag;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			it = make_item(2'($urandom_range(0, 3)), rand40(), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), rand40());
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 45)
			adv = {1'b0, mission} + (TIME_W+1)'($urandom_range(0, 200));
		else if (r < 75)
			adv = {1'b0, mission} + (TIME_W+1)'(cur_burn) + (TIME_W+1)'($urandom_range(0, 100));
		else if (r < 92)
			adv = {1'b0, mission} + (TIME_W+1)'($urandom());
		else
			adv = {1'b0, rand40()};
		mission = adv[TIME_W] ? TIME_MAX : adv[TIME_W-1:0];
		it.time_ms = mission;

		r = $urandom_range(0, 99);
		if (r < 68)
			it.func = FUNC_TICK;
		else if (r < 83)
			it.func = FUNC_OPEN;
		else if (r < 97)
			it.func = FUNC_CORR;
		else
			it.func = FUNC_RSVD;

		r = $urandom_range(0, 99);
		if (r < 55)
			it.stored_mode = MODE_OPENING;
		else if (r < 75)
			it.stored_mode = MODE_WAITING;
		else if (r < 95)
			it.stored_mode = MODE_STOPPED;
		else
			it.stored_mode = MODE_UNKNOWN;
		it.stored_mode_ok = ($urandom_range(0, 19) != 0);

		// corrections: small nudges, exactly one burn wait, or anything at all
		r = $urandom_range(0, 99);
		if (r < 50)
			mag = TIME_W'($urandom_range(0, 300000));
		else if (r < 80)
			mag = TIME_W'(cur_burn);
		else
			mag = rand40();
		if ($urandom_range(0, 1))
			mag = '0 - mag;
		it.correction_ms = mag;
	endtask

	// Present one item; valid stays up until the block takes it.
	// Returns on the falling edge after acceptance.
	task automatic send(input req_t it);
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// bursts of back-to-back items separated by random gaps (sometimes none)
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Let the block drain: every expected result in, then a settling wait
	// so a trailing open request or correction has surely finished.
	task automatic settle();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Receiver: stretches of free flow, coin-flip stalls and heavy choking.
	// On request it holds off once for a long stretch so the block backs up
	// into its input.
	initial begin
		flow_t flow;
		int    span;
		logic  held;
		rsp_ready = 1'b0;
		held = 1'b0;
		forever begin
			flow = flow_t'($urandom_range(0, 2));
			span = $urandom_range(1, 40);
			repeat (span) begin
				@(negedge clk);
				if (hold_request && !held) begin
					held = 1'b1;
					rsp_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end else begin
					case (flow)
					FLOW_FREE:   rsp_ready <= 1'b1;
					FLOW_RANDOM: rsp_ready <= ($urandom_range(0, 1) == 1);
					default:     rsp_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	initial begin
		req_t              it;
		req_t              plan [$];
		logic [TIME_W-1:0] auto_val;
		logic [BURN_W-1:0] burn_val;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_request = 1'b0;
		burst_left = 0;
		mission = '0;
		cur_burn = BURN_WAIT_RST;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk with reset register values: reserved kind, unreadable
		// mode (pending request must survive it), open from stopped, waiting
		// on a burn, correction saturating low then high, table end, unknown
		// mode eating a request, restart of a finished sequence, auto-open at
		// the top of time where the burn wait saturates and the run limit bites.
		plan.push_back(make_item(FUNC_RSVD, 40'd77, MODE_OPENING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd500, MODE_WAITING, 1'b0, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd1000, MODE_WAITING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_OPEN, 40'd0, MODE_WAITING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd1500, MODE_STOPPED, 1'b0, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd5000, MODE_STOPPED, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd6000, MODE_OPENING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_CORR, 40'd0, MODE_WAITING, 1'b1, CORR_MOST_NEG));
		plan.push_back(make_item(FUNC_TICK, 40'd7000, MODE_OPENING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_CORR, 40'd0, MODE_WAITING, 1'b1, CORR_MOST_POS));
		plan.push_back(make_item(FUNC_CORR, 40'd0, MODE_WAITING, 1'b1, CORR_MOST_POS));
		plan.push_back(make_item(FUNC_TICK, TIME_MAX, MODE_OPENING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, TIME_MAX, MODE_OPENING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_OPEN, 40'd0, MODE_WAITING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd10, MODE_UNKNOWN, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_OPEN, 40'd0, MODE_WAITING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd20, MODE_OPENING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, TIME_MAX, MODE_WAITING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, 40'd0, MODE_WAITING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_CORR, 40'd0, MODE_WAITING, 1'b1, 40'd0));
		plan.push_back(make_item(FUNC_TICK, AUTO_OPEN_RST, MODE_STOPPED, 1'b1, 40'd0));
		foreach (plan[k]) begin
			send(plan[k]);
			pace();
		end

		// Random traffic under four register settings: zero delays, the
		// maximum of both, a random mix, and the reset values written back.
		for (int set_no = 0; set_no < 4; set_no++) begin
			settle();
			case (set_no)
			0: begin
				auto_val = '0;
				burn_val = '0;
				mission = TIME_W'($urandom_range(0, 1000));
			end
			1: begin
				auto_val = TIME_MAX;
				burn_val = '1;
				mission = TIME_MAX - TIME_W'($urandom_range(0, 1 << 26));
			end
			2: begin
				auto_val = rand40();
				burn_val = BURN_W'($urandom_range(1, 5000));
				mission = rand40();
			end
			default: begin
				auto_val = AUTO_OPEN_RST;
				burn_val = BURN_WAIT_RST;
				mission = AUTO_OPEN_RST - TIME_W'($urandom_range(0, 2000000));
			end
			endcase
			apb_write(ADDR_AUTO_OPEN, APB_DW'(auto_val));
			apb_write(ADDR_BURN_WAIT, APB_DW'(burn_val));
			cur_burn = burn_val;

			if (set_no == 2) begin
				// back-pressure: receiver stalls for a long time while ticks
				// keep coming back-to-back, filling the block up
				hold_request = 1'b1;
				send(make_item(FUNC_OPEN, mission, MODE_WAITING, 1'b1, 40'd0));
				repeat (PRESSURE_LEN) begin
					next_random_item(it);
					it.func = FUNC_TICK;
					it.stored_mode_ok = 1'b1;
					send(it);
				end
			end

			repeat (ITEMS_PER_SET) begin
				next_random_item(it);
				send(it);
				pace();
			end
		end

		settle();
		$display("Run covered %0d items in and %0d results checked:", items_taken,
			results_checked);
		$display("directed corner cases, four register settings and a long output hold.");
		if (mismatches == 0 && pending == 0) begin
			$display("deployment_step_sequencer_unit verification clean");
		end else begin
			if (pending != 0)
				$error("%0d expected results never arrived", pending);
			$display("deployment_step_sequencer_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/dss_pkg.sv
sv/dss_sequencer.sv
sv/dss_datapath.sv
sv/deployment_step_sequencer_unit.sv
bench/deploy_seq_checker.sv
bench/testbench.sv
